### src/pras_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the PCA reconstruction
// anomaly scorer. No dependencies.
package pras_pkg;

    localparam int LANES      = 3;
    localparam int ROWS       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int LANE_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEATURE_MEAN      = 3'd0,
        REG_INVERSE_SCALE     = 3'd1,
        REG_PCA_CENTER        = 3'd2,
        REG_COMPONENT_ROW_A   = 3'd3,
        REG_COMPONENT_ROW_B   = 3'd4,
        REG_COMPONENT_ROW_C   = 3'd5,
        REG_COMPONENTS_IN_USE = 3'd6,
        REG_THRESHOLD_SQUARED = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic signed [15:0] humidity;
        logic signed [15:0] motion;
    } t_in_item;

    typedef struct packed {
        logic [31:0] squared_error;
        logic        anomaly;
    } t_out_item;

    // Clamp a wide signed intermediate to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
        logic signed [15:0] res;
        if (v > 35'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -35'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

### src/pca_reconstruction_anomaly_score.sv
`timescale 1ns / 1ps
// Nine-stage pipeline from input transaction to result valid; takes one item
// per cycle until a stall fills it; each stage holds at most one item and
// advances whenever the stage after it is empty or advancing (bubbles collapse).
// The multiplier stages (scale, projection, reconstruction, square) set the depth.
// Synchronous active-low reset empties the pipeline and loads register defaults.
module pca_reconstruction_anomaly_score (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pras_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pras_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_we,
    input  logic [pras_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pras_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pras_pkg::*;

    localparam int STAGES = 9;

    // Configuration registers.
    logic [47:0] r_mean, r_inv, r_center;
    logic [47:0] r_row [ROWS];
    logic [1:0]  r_used;
    logic [31:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean   <= '0;
            r_inv    <= '0;
            r_center <= '0;
            r_row[0] <= '0;
            r_row[1] <= '0;
            r_row[2] <= '0;
            r_used   <= 2'd3;
            r_thr    <= 32'hffff_ffff;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FEATURE_MEAN:      r_mean   <= i_cfg_data;
                REG_INVERSE_SCALE:     r_inv    <= i_cfg_data;
                REG_PCA_CENTER:        r_center <= i_cfg_data;
                REG_COMPONENT_ROW_A:   r_row[0] <= i_cfg_data;
                REG_COMPONENT_ROW_B:   r_row[1] <= i_cfg_data;
                REG_COMPONENT_ROW_C:   r_row[2] <= i_cfg_data;
                REG_COMPONENTS_IN_USE: r_used   <= i_cfg_data[1:0];
                REG_THRESHOLD_SQUARED: r_thr    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Signed lane views of the packed registers.
    logic signed [15:0] mean_l [LANES];
    logic signed [15:0] inv_l  [LANES];
    logic signed [15:0] ctr_l  [LANES];
    logic signed [15:0] w_l    [ROWS][LANES];
    logic signed [15:0] x_l    [LANES];

    always_comb begin
        x_l[0] = i_in_data.temperature;
        x_l[1] = i_in_data.humidity;
        x_l[2] = i_in_data.motion;
        for (int j = 0; j < LANES; j++) begin
            mean_l[j] = r_mean[LANE_W*j +: LANE_W];
            inv_l[j]  = r_inv[LANE_W*j +: LANE_W];
            ctr_l[j]  = r_center[LANE_W*j +: LANE_W];
            for (int k = 0; k < ROWS; k++) begin
                w_l[k][j] = r_row[k][LANE_W*j +: LANE_W];
            end
        end
    end

    // Stage handshake: ld[k] means stage k may capture new contents.
    logic [STAGES:1]   r_vld;
    logic [STAGES+1:1] ld;

    always_comb begin
        ld[STAGES+1] = i_out_ready;
        for (int k = STAGES; k >= 1; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_in_ready = ld[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Datapath registers and their next values.
    logic signed [16:0] r_d1 [LANES], n_d1 [LANES];
    logic signed [32:0] r_p2 [LANES], n_p2 [LANES];
    logic signed [15:0] r_s3 [LANES], n_s3 [LANES];
    logic signed [15:0] r_c3 [LANES], n_c3 [LANES];
    logic signed [31:0] r_m4 [ROWS][LANES], n_m4 [ROWS][LANES];
    logic signed [15:0] r_s4 [LANES];
    logic signed [15:0] r_z5 [ROWS], n_z5 [ROWS];
    logic signed [15:0] r_s5 [LANES];
    logic signed [31:0] r_m6 [ROWS][LANES], n_m6 [ROWS][LANES];
    logic signed [15:0] r_s6 [LANES];
    logic signed [16:0] r_e7 [LANES], n_e7 [LANES];
    logic [31:0]        r_q8 [LANES], n_q8 [LANES];
    t_out_item          r_out, n_out;

    logic signed [34:0] acc5 [ROWS];
    logic signed [34:0] acc7 [LANES];
    logic signed [15:0] b7   [LANES];
    logic signed [15:0] rec7 [LANES];
    logic signed [33:0] sq8  [LANES];
    logic [33:0]        sum9;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            // Stage 1: offset by the scaler mean.
            n_d1[j] = 17'(x_l[j]) - 17'(mean_l[j]);
            // Stage 2: multiply by the reciprocal deviation.
            n_p2[j] = 33'(r_d1[j]) * 33'(inv_l[j]);
            // Stage 3: round to Q4.12 and center.
            n_s3[j] = sat16((35'(r_p2[j]) + 35'sd128) >>> 8);
            n_c3[j] = sat16(35'(n_s3[j]) - 35'(ctr_l[j]));
        end
        // Stage 4: projection products.
        for (int k = 0; k < ROWS; k++) begin
            for (int j = 0; j < LANES; j++) begin
                n_m4[k][j] = 32'(w_l[k][j]) * 32'(r_c3[j]);
            end
        end
        // Stage 5: component scores; unused rows score zero and drop out below.
        for (int k = 0; k < ROWS; k++) begin
            acc5[k] = 35'(r_m4[k][0]) + 35'(r_m4[k][1]) + 35'(r_m4[k][2]) + 35'sd8192;
            n_z5[k] = (2'(k) < r_used) ? sat16(acc5[k] >>> 14) : 16'sd0;
        end
        // Stage 6: reconstruction products through the transposed rows.
        for (int k = 0; k < ROWS; k++) begin
            for (int j = 0; j < LANES; j++) begin
                n_m6[k][j] = 32'(w_l[k][j]) * 32'(r_z5[k]);
            end
        end
        for (int j = 0; j < LANES; j++) begin
            // Stage 7: reconstructed feature and its error.
            acc7[j] = 35'(r_m6[0][j]) + 35'(r_m6[1][j]) + 35'(r_m6[2][j]) + 35'sd8192;
            b7[j]   = sat16(acc7[j] >>> 14);
            rec7[j] = sat16(35'(ctr_l[j]) + 35'(b7[j]));
            n_e7[j] = 17'(r_s6[j]) - 17'(rec7[j]);
            // Stage 8: square; the magnitude stays below 2^32.
            sq8[j]  = 34'(r_e7[j]) * 34'(r_e7[j]);
            n_q8[j] = sq8[j][31:0];
        end
        // Stage 9: all terms are non-negative, so one final clamp suffices.
        sum9 = 34'(r_q8[0]) + 34'(r_q8[1]) + 34'(r_q8[2]);
        n_out.squared_error = (sum9[33:32] != 2'b00) ? 32'hffff_ffff : sum9[31:0];
        n_out.anomaly       = (n_out.squared_error > r_thr);
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) r_d1 <= n_d1;
        if (ld[2]) r_p2 <= n_p2;
        if (ld[3]) begin
            r_s3 <= n_s3;
            r_c3 <= n_c3;
        end
        if (ld[4]) begin
            r_m4 <= n_m4;
            r_s4 <= r_s3;
        end
        if (ld[5]) begin
            r_z5 <= n_z5;
            r_s5 <= r_s4;
        end
        if (ld[6]) begin
            r_m6 <= n_m6;
            r_s6 <= r_s5;
        end
        if (ld[7]) r_e7 <= n_e7;
        if (ld[8]) r_q8 <= n_q8;
        if (ld[9]) r_out <= n_out;
    end

    assign o_out_valid = r_vld[STAGES];
    assign o_out_data  = r_out;

endmodule

### src/pras_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the PCA reconstruction anomaly scorer and the bind
// that attaches them. Depends on pras_pkg.
module pras_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input pras_pkg::t_out_item                o_out_data
);
    import pras_pkg::*;

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // An alert needs a nonzero error, since the threshold is never negative.
    a_alert_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.anomaly |-> o_out_data.squared_error != 32'd0)
        else $error("anomaly raised with zero error");

    // With no result waiting at the output, there is room for a new transaction.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while the output stage is empty");

endmodule

bind pca_reconstruction_anomaly_score pras_checker u_pras_checker (.*);

### tb/tb_pca_reconstruction_anomaly_score.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PCA reconstruction anomaly scorer.
// Depends on pras_pkg and pca_reconstruction_anomaly_score; predicts every score in place.
module tb_pca_reconstruction_anomaly_score;
    import pras_pkg::*;

    localparam int     PIPE_LATENCY = 9;
    localparam int     QUIET_LIMIT  = 2000;
    localparam longint ERR_CEIL     = 64'sd4294967295;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Local copy of the register file, updated as each write is issued.
    logic [47:0] mean_reg   = '0;
    logic [47:0] inv_reg    = '0;
    logic [47:0] center_reg = '0;
    logic [47:0] row_reg [ROWS] = '{default: '0};
    logic [1:0]  rows_used  = 2'd3;
    logic [31:0] thresh_sq  = 32'hffff_ffff;

    t_out_item score_q [$];
    int        error_count        = 0;
    int        quiet_cycles       = 0;
    int        sender_idle_pct    = 0;
    int        receiver_stall_pct = 0;
    int        stall_hold         = 0;

    pca_reconstruction_anomaly_score DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint lane_of(input logic [47:0] regv, input int j);
        return longint'($signed(regv[16*j +: 16]));
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Round half up, then floor-shift by n.
    function automatic longint round_drop(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic t_out_item predict_score(input t_in_item it);
        t_out_item res;
        longint    x [LANES];
        longint    s [LANES];
        longint    c [LANES];
        longint    z [ROWS];
        longint    acc;
        longint    r;
        longint    e;
        longint    total;
        x[0] = longint'($signed(it.temperature));
        x[1] = longint'($signed(it.humidity));
        x[2] = longint'($signed(it.motion));
        total = 0;
        for (int j = 0; j < LANES; j++) begin
            s[j] = clamp16(round_drop((x[j] - lane_of(mean_reg, j)) * lane_of(inv_reg, j), 8));
            c[j] = clamp16(s[j] - lane_of(center_reg, j));
        end
        for (int k = 0; k < ROWS; k++) begin
            z[k] = 0;
            if (k < int'(rows_used)) begin
                acc = 0;
                for (int j = 0; j < LANES; j++) acc += lane_of(row_reg[k], j) * c[j];
                z[k] = clamp16(round_drop(acc, 14));
            end
        end
        for (int j = 0; j < LANES; j++) begin
            acc = 0;
            for (int k = 0; k < int'(rows_used); k++) acc += lane_of(row_reg[k], j) * z[k];
            r = clamp16(lane_of(center_reg, j) + clamp16(round_drop(acc, 14)));
            e = s[j] - r;
            total += e * e;
            if (total > ERR_CEIL) total = ERR_CEIL;
        end
        res.squared_error = total[31:0];
        res.anomaly       = (total > longint'(thresh_sq));
        return res;
    endfunction

    // Input transactions queue a prediction; output transactions are checked against it.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        logic      moved;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                score_q.insert(score_q.size(), predict_score(i_in_data));
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (score_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h/%b", $time,
                             o_out_data.squared_error, o_out_data.anomaly);
                    error_count++;
                end else begin
                    want = score_q.pop_front();
                    if (o_out_data.squared_error !== want.squared_error) begin
                        $display("%0t: squared_error expected %h actual %h", $time,
                                 want.squared_error, o_out_data.squared_error);
                        error_count++;
                    end
                    if (o_out_data.anomaly !== want.anomaly) begin
                        $display("%0t: anomaly expected %b actual %b", $time,
                                 want.anomaly, o_out_data.anomaly);
                        error_count++;
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_out_ready <= 1'b0;
            stall_hold--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin : watchdog
        do @(negedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("tb_pca_reconstruction_anomaly_score: FAIL");
        $finish;
    end

    // Entered and left at a falling edge. Valid stays high between back-to-back items.
    task automatic send_item(input t_in_item it);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [47:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_FEATURE_MEAN:      mean_reg   = data;
            REG_INVERSE_SCALE:     inv_reg    = data;
            REG_PCA_CENTER:        center_reg = data;
            REG_COMPONENT_ROW_A:   row_reg[0] = data;
            REG_COMPONENT_ROW_B:   row_reg[1] = data;
            REG_COMPONENT_ROW_C:   row_reg[2] = data;
            REG_COMPONENTS_IN_USE: rows_used  = data[1:0];
            REG_THRESHOLD_SQUARED: thresh_sq  = data[31:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop offering, let every expected result drain, then give the pipe time to empty.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (score_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 3) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_lane(input int span, input int full_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return 16'h7fff;
        if (roll < 6) return 16'h8000;
        if (roll < 6 + full_pct) return 16'($urandom);
        return 16'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic t_in_item rand_sample();
        t_in_item it;
        it.temperature = pick_lane(16'h0600, 40);
        it.humidity    = pick_lane(16'h0600, 40);
        it.motion      = pick_lane(16'h0600, 40);
        return it;
    endfunction

    task automatic randomize_config();
        logic [31:0] thr;
        int          roll;
        write_reg(REG_FEATURE_MEAN,
                  {pick_lane(16'h0200, 10), pick_lane(16'h0200, 10), pick_lane(16'h0200, 10)});
        write_reg(REG_INVERSE_SCALE,
                  {pick_lane(16'h1000, 10), pick_lane(16'h1000, 10), pick_lane(16'h1000, 10)});
        write_reg(REG_PCA_CENTER,
                  {pick_lane(16'h1000, 10), pick_lane(16'h1000, 10), pick_lane(16'h1000, 10)});
        write_reg(REG_COMPONENT_ROW_A,
                  {pick_lane(16'h4000, 10), pick_lane(16'h4000, 10), pick_lane(16'h4000, 10)});
        write_reg(REG_COMPONENT_ROW_B,
                  {pick_lane(16'h4000, 10), pick_lane(16'h4000, 10), pick_lane(16'h4000, 10)});
        write_reg(REG_COMPONENT_ROW_C,
                  {pick_lane(16'h4000, 10), pick_lane(16'h4000, 10), pick_lane(16'h4000, 10)});
        // Upper bits carry noise; only the low bits of the narrow registers count.
        write_reg(REG_COMPONENTS_IN_USE,
                  {16'($urandom), 30'($urandom), 2'($urandom_range(3))});
        roll = $urandom_range(3);
        if (roll == 0) thr = $urandom;
        else if (roll == 1) thr = 32'hffff_ffff;
        else thr = $urandom_range(32'h1000_0000);
        write_reg(REG_THRESHOLD_SQUARED, {16'($urandom), thr});
    endtask

    task automatic test_reset_defaults();
        send_item('{16'sh7fff, 16'sh8000, 16'sh0000});
        send_item('{16'sh8000, 16'sh7fff, -16'sh0001});
        send_item('{16'sh1234, -16'sh0567, 16'sh0001});
        wait_quiet();
    endtask

    // Unit scale and a single identity row: only feature 0 is reconstructed.
    task automatic test_unit_scaling();
        write_reg(REG_FEATURE_MEAN, '0);
        write_reg(REG_INVERSE_SCALE, {3{16'h1000}});
        write_reg(REG_PCA_CENTER, '0);
        write_reg(REG_COMPONENT_ROW_A, {16'h0000, 16'h0000, 16'h4000});
        write_reg(REG_COMPONENT_ROW_B, '0);
        write_reg(REG_COMPONENT_ROW_C, '0);
        write_reg(REG_COMPONENTS_IN_USE, 48'd1);
        write_reg(REG_THRESHOLD_SQUARED, 48'd0);
        send_item('{16'sh0000, 16'sh0000, 16'sh0000});
        send_item('{16'sh0000, 16'sh0000, 16'sh0001});
        send_item('{16'sh0100, 16'sh0000, 16'sh0000});
        send_item('{16'sh7fff, 16'sh8000, 16'sh0001});
        wait_quiet();
    endtask

    // Extreme registers drive the 16-bit clamps of the datapath into saturation.
    task automatic test_saturation();
        write_reg(REG_FEATURE_MEAN, {16'h8000, 16'h7fff, 16'h8000});
        write_reg(REG_INVERSE_SCALE, {16'h7fff, 16'h8000, 16'h7fff});
        write_reg(REG_PCA_CENTER, {16'h8000, 16'h7fff, 16'h0000});
        write_reg(REG_COMPONENT_ROW_A, {16'h8000, 16'h7fff, 16'h8000});
        write_reg(REG_COMPONENT_ROW_B, {16'h7fff, 16'h8000, 16'h7fff});
        write_reg(REG_COMPONENT_ROW_C, {16'h8000, 16'h8000, 16'h7fff});
        write_reg(REG_COMPONENTS_IN_USE, 48'd3);
        write_reg(REG_THRESHOLD_SQUARED, 48'h0000_ffff_fffe);
        send_item('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_item('{16'sh8000, 16'sh8000, 16'sh8000});
        send_item('{16'sh7fff, 16'sh8000, 16'sh0000});
        send_item('{16'sh0000, 16'sh0000, 16'sh0000});
        wait_quiet();
    endtask

    // Sweeps the rows in use from zero to three; zero rows leaves the reconstruction at the center.
    task automatic test_component_counts();
        write_reg(REG_FEATURE_MEAN, {16'h0080, -16'sh0100, 16'h0040});
        write_reg(REG_INVERSE_SCALE, {16'h0c00, 16'h1400, 16'h0800});
        write_reg(REG_PCA_CENTER, {16'h0200, -16'sh0300, 16'h0100});
        write_reg(REG_COMPONENT_ROW_A, {16'h1a00, 16'h2400, 16'h1800});
        write_reg(REG_COMPONENT_ROW_B, {-16'sh2000, 16'h0800, 16'h2c00});
        write_reg(REG_COMPONENT_ROW_C, {16'h2200, -16'sh2a00, 16'h0600});
        write_reg(REG_THRESHOLD_SQUARED, 48'h0000_0100_0000);
        for (int used = 0; used < 4; used++) begin
            write_reg(REG_COMPONENTS_IN_USE, 48'(used));
            send_item('{16'sh0340, -16'sh0220, 16'sh0110});
            send_item('{-16'sh0500, 16'sh0180, 16'sh0600});
            wait_quiet();
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int seg = 0; seg < 4; seg++) begin
            randomize_config();
            for (int n = 0; n < n_items / 4; n++) send_item(rand_sample());
            wait_quiet();
        end
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, 340);
        run_phase(75, 0, 340);
        run_phase(0, 75, 340);
        run_phase(8, 8, 340);
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        randomize_config();
        @(posedge i_clk);
        stall_hold = 300;
        @(negedge i_clk);
        for (int n = 0; n < 48; n++) send_item(rand_sample());
        wait_quiet();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_unit_scaling();
        test_saturation();
        test_component_counts();
        test_random_traffic();
        test_backpressure();
        repeat (2 * PIPE_LATENCY) @(negedge i_clk);
        if (error_count == 0 && score_q.size() == 0) begin
            $display("tb_pca_reconstruction_anomaly_score: PASS");
        end else begin
            $display("tb_pca_reconstruction_anomaly_score: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
src/pras_pkg.sv
src/pca_reconstruction_anomaly_score.sv
src/pras_checker.sv
tb/tb_pca_reconstruction_anomaly_score.sv
